// ----- rtl/thqm_pkg.sv -----
package thqm_pkg;

	localparam int DIFF_W    = 33;
	localparam int VAL_W     = 72;
	localparam int ACC_W     = 106;
	localparam int REM_W     = VAL_W + 1;
	localparam int MUL_STEPS = DIFF_W;
	localparam int CNT_W     = 7;
	localparam int PC_W      = 5;
	localparam int IDX_W     = 8;
	localparam int CFG_W     = 32;
	localparam int COORD_W   = 32;
	localparam int TOL_W     = 16;

	localparam logic [IDX_W-1:0] REG_EDGE_TOL  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_DEGEN_LIM = IDX_W'(1);

	localparam logic [TOL_W-1:0] EDGE_TOL_RST  = TOL_W'(66);
	localparam logic [CFG_W-1:0] DEGEN_LIM_RST = CFG_W'(1);

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);

	typedef enum logic [3:0] {
		OP_CLR, OP_MUL, OP_STO, OP_NORM, OP_NW, OP_HIT,
		OP_LDS, OP_WCHK, OP_DIVI, OP_DIV, OP_UPD, OP_END
	} op_t;

	// wide operand, also destination of a store and source of a shifted load
	typedef enum logic [2:0] {
		SA_D1, SA_D2, SA_D3, SA_D7, SA_DEN, SA_NU, SA_NV, SA_NW
	} sel_a_t;

	typedef enum logic [2:0] {
		SB_D3, SB_D4, SB_D5, SB_D6, SB_AY, SB_BY, SB_CY, SB_TOL
	} sel_b_t;

	typedef struct packed {
		op_t    op;
		sel_a_t a_sel;
		sel_b_t b_sel;
	} uop_t;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		uop_t uop;
		logic mul_first;
		logic mul_last;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic hit_ok;
		logic acc_neg;
		logic out_full;
	} dp_sts_t;

	localparam logic [PC_W-1:0] PC_END = PC_W'(31);

	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{op: OP_END, a_sel: SA_D1, b_sel: SB_D3};
		unique case (pc)
			5'd0:  u = '{op: OP_CLR,  a_sel: SA_D1,  b_sel: SB_D3};
			5'd1:  u = '{op: OP_MUL,  a_sel: SA_D1,  b_sel: SB_D3};
			5'd2:  u = '{op: OP_MUL,  a_sel: SA_D2,  b_sel: SB_D4};
			5'd3:  u = '{op: OP_STO,  a_sel: SA_DEN, b_sel: SB_D3};
			5'd4:  u = '{op: OP_CLR,  a_sel: SA_D1,  b_sel: SB_D3};
			5'd5:  u = '{op: OP_MUL,  a_sel: SA_D1,  b_sel: SB_D5};
			5'd6:  u = '{op: OP_MUL,  a_sel: SA_D2,  b_sel: SB_D6};
			5'd7:  u = '{op: OP_STO,  a_sel: SA_NU,  b_sel: SB_D3};
			5'd8:  u = '{op: OP_CLR,  a_sel: SA_D1,  b_sel: SB_D3};
			5'd9:  u = '{op: OP_MUL,  a_sel: SA_D7,  b_sel: SB_D5};
			5'd10: u = '{op: OP_MUL,  a_sel: SA_D3,  b_sel: SB_D6};
			5'd11: u = '{op: OP_STO,  a_sel: SA_NV,  b_sel: SB_D3};
			5'd12: u = '{op: OP_NORM, a_sel: SA_D1,  b_sel: SB_D3};
			5'd13: u = '{op: OP_NW,   a_sel: SA_D1,  b_sel: SB_D3};
			5'd14: u = '{op: OP_HIT,  a_sel: SA_D1,  b_sel: SB_D3};
			5'd15: u = '{op: OP_LDS,  a_sel: SA_NU,  b_sel: SB_D3};
			5'd16: u = '{op: OP_MUL,  a_sel: SA_DEN, b_sel: SB_TOL};
			5'd17: u = '{op: OP_WCHK, a_sel: SA_D1,  b_sel: SB_D3};
			5'd18: u = '{op: OP_LDS,  a_sel: SA_NV,  b_sel: SB_D3};
			5'd19: u = '{op: OP_MUL,  a_sel: SA_DEN, b_sel: SB_TOL};
			5'd20: u = '{op: OP_WCHK, a_sel: SA_D1,  b_sel: SB_D3};
			5'd21: u = '{op: OP_LDS,  a_sel: SA_NW,  b_sel: SB_D3};
			5'd22: u = '{op: OP_MUL,  a_sel: SA_DEN, b_sel: SB_TOL};
			5'd23: u = '{op: OP_WCHK, a_sel: SA_D1,  b_sel: SB_D3};
			5'd24: u = '{op: OP_CLR,  a_sel: SA_D1,  b_sel: SB_D3};
			5'd25: u = '{op: OP_MUL,  a_sel: SA_NU,  b_sel: SB_AY};
			5'd26: u = '{op: OP_MUL,  a_sel: SA_NV,  b_sel: SB_BY};
			5'd27: u = '{op: OP_MUL,  a_sel: SA_NW,  b_sel: SB_CY};
			5'd28: u = '{op: OP_DIVI, a_sel: SA_D1,  b_sel: SB_D3};
			5'd29: u = '{op: OP_DIV,  a_sel: SA_D1,  b_sel: SB_D3};
			5'd30: u = '{op: OP_UPD,  a_sel: SA_D1,  b_sel: SB_D3};
			default: u = '{op: OP_END, a_sel: SA_D1, b_sel: SB_D3};
		endcase
		return u;
	endfunction

endpackage

// ----- rtl/thqm_if.sv -----
interface thqm_cand_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] query_x;
	logic signed [31:0] query_z;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] c_x;
	logic signed [31:0] c_y;
	logic signed [31:0] c_z;
	logic               last_triangle;

	modport source (output valid, query_x, query_z, a_x, a_y, a_z, b_x, b_y, b_z,
		c_x, c_y, c_z, last_triangle, input ready);
	modport sink (input valid, query_x, query_z, a_x, a_y, a_z, b_x, b_y, b_z,
		c_x, c_y, c_z, last_triangle, output ready);
endinterface

interface thqm_res_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [31:0] height;

	modport source (output valid, found, height, input ready);
	modport sink (input valid, found, height, output ready);
endinterface

interface thqm_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/thqm_ctrl.sv -----
module thqm_ctrl
	import thqm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cand_valid,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t            state_q, state_d;
	logic [PC_W-1:0]   pc_q, pc_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	uop_t              uop;

	assign uop = ucode(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cand_valid) begin
					state_d = ST_RUN;
					pc_d    = '0;
					cnt_d   = '0;
				end
			end
			ST_RUN: begin
				case (uop.op)
					OP_MUL: begin
						if (cnt_q == MUL_LAST) begin
							cnt_d = '0;
							pc_d  = pc_q + PC_W'(1);
						end else begin
							cnt_d = cnt_q + CNT_W'(1);
						end
					end
					OP_DIV: begin
						if (cnt_q == DIV_LAST) begin
							cnt_d = '0;
							pc_d  = pc_q + PC_W'(1);
						end else begin
							cnt_d = cnt_q + CNT_W'(1);
						end
					end
					OP_HIT:  pc_d = sts.hit_ok ? pc_q + PC_W'(1) : PC_END;
					OP_WCHK: pc_d = sts.acc_neg ? PC_END : pc_q + PC_W'(1);
					OP_END:  state_d = sts.last ? ST_EMIT : ST_IDLE;
					default: pc_d = pc_q + PC_W'(1);
				endcase
			end
			ST_EMIT: begin
				if (!sts.out_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load      = (state_q == ST_IDLE) && cand_valid;
		cmd.exec      = (state_q == ST_RUN);
		cmd.uop       = uop;
		cmd.mul_first = (cnt_q == '0);
		cmd.mul_last  = (cnt_q == MUL_LAST);
		cmd.emit      = (state_q == ST_EMIT) && !sts.out_full;
	end

endmodule

// ----- rtl/thqm_dp.sv -----
module thqm_dp
	import thqm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	thqm_cand_if.sink cand,
	thqm_res_if.source res,
	thqm_cfg_if.sink  cfg,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts
);

	logic [TOL_W-1:0]          tol_q;
	logic [CFG_W-1:0]          lim_q;
	logic signed [DIFF_W-1:0]  d1_q, d2_q, d3_q, d4_q, d5_q, d6_q, d7_q;
	logic signed [COORD_W-1:0] ay_q, by_q, cy_q;
	logic                      last_q;
	logic signed [VAL_W-1:0]   den_q, nu_q, nv_q, nw_q;
	logic signed [ACC_W-1:0]   acc_q, mcand_q;
	logic [DIFF_W-1:0]         mplier_q;
	logic [ACC_W-1:0]          numq_q;
	logic [REM_W-1:0]          rem_q;
	logic                      neg_q;
	logic signed [COORD_W-1:0] best_q;
	logic                      have_q;
	logic                      out_valid_q;
	logic                      found_q;
	logic signed [COORD_W-1:0] height_q;

	logic signed [ACC_W-1:0]   a_ext, cur_a, addend;
	logic signed [DIFF_W-1:0]  b_ext;
	logic [DIFF_W-1:0]         cur_b;
	logic signed [VAL_W-1:0]   stor_src;
	logic [ACC_W-1:0]          mag;
	logic [REM_W-1:0]          dvs, r2;
	logic                      ge;
	logic signed [COORD_W-1:0] h;
	logic                      q_big;

	function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] p,
		input logic signed [COORD_W-1:0] m);
		return DIFF_W'(p) - DIFF_W'(m);
	endfunction

	always_comb begin
		case (cmd.uop.a_sel)
			SA_D1:   a_ext = ACC_W'(d1_q);
			SA_D2:   a_ext = ACC_W'(d2_q);
			SA_D3:   a_ext = ACC_W'(d3_q);
			SA_D7:   a_ext = ACC_W'(d7_q);
			SA_DEN:  a_ext = ACC_W'(den_q);
			SA_NU:   a_ext = ACC_W'(nu_q);
			SA_NV:   a_ext = ACC_W'(nv_q);
			default: a_ext = ACC_W'(nw_q);
		endcase
		case (cmd.uop.b_sel)
			SB_D3:   b_ext = d3_q;
			SB_D4:   b_ext = d4_q;
			SB_D5:   b_ext = d5_q;
			SB_D6:   b_ext = d6_q;
			SB_AY:   b_ext = DIFF_W'(ay_q);
			SB_BY:   b_ext = DIFF_W'(by_q);
			SB_CY:   b_ext = DIFF_W'(cy_q);
			default: b_ext = $signed({{(DIFF_W-TOL_W){1'b0}}, tol_q});
		endcase
		cur_a    = cmd.mul_first ? a_ext : mcand_q;
		cur_b    = cmd.mul_first ? b_ext : mplier_q;
		addend   = cur_b[0] ? cur_a : '0;
		stor_src = acc_q[VAL_W-1:0];
		mag      = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		dvs      = {den_q, 1'b0};
		r2       = {rem_q[REM_W-2:0], numq_q[ACC_W-1]};
		ge       = (r2 >= dvs);
		q_big    = (numq_q[ACC_W-1:COORD_W-1] != '0);
		// round-to-nearest quotient, saturated to 32 bits
		if (neg_q) h = q_big ? {1'b1, {(COORD_W-1){1'b0}}} : -$signed(numq_q[COORD_W-1:0]);
		else       h = q_big ? {1'b0, {(COORD_W-1){1'b1}}} : $signed(numq_q[COORD_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= EDGE_TOL_RST;
			lim_q       <= DEGEN_LIM_RST;
			best_q      <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_EDGE_TOL)  tol_q <= cfg.data[TOL_W-1:0];
				if (cfg.index == REG_DEGEN_LIM) lim_q <= cfg.data;
			end
			if (res.ready) out_valid_q <= 1'b0;
			if (cmd.exec && cmd.uop.op == OP_UPD) begin
				if (!have_q || h > best_q) begin
					best_q <= h;
					have_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				best_q      <= '0;
				have_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found_q  <= have_q;
			height_q <= have_q ? best_q : '0;
		end
		if (cmd.load) begin
			d1_q   <= sdiff(cand.b_z, cand.c_z);
			d2_q   <= sdiff(cand.c_x, cand.b_x);
			d3_q   <= sdiff(cand.a_x, cand.c_x);
			d4_q   <= sdiff(cand.a_z, cand.c_z);
			d5_q   <= sdiff(cand.query_x, cand.c_x);
			d6_q   <= sdiff(cand.query_z, cand.c_z);
			d7_q   <= sdiff(cand.c_z, cand.a_z);
			ay_q   <= cand.a_y;
			by_q   <= cand.b_y;
			cy_q   <= cand.c_y;
			last_q <= cand.last_triangle;
		end
		if (cmd.exec) begin
			case (cmd.uop.op)
				OP_CLR: acc_q <= '0;
				OP_MUL: begin
					// shift-add, top multiplier bit has negative weight
					acc_q    <= cmd.mul_last ? acc_q - addend : acc_q + addend;
					mcand_q  <= cur_a <<< 1;
					mplier_q <= cur_b >> 1;
				end
				OP_STO: begin
					case (cmd.uop.a_sel)
						SA_DEN:  den_q <= stor_src;
						SA_NU:   nu_q  <= stor_src;
						default: nv_q  <= stor_src;
					endcase
				end
				OP_NORM: begin
					if (den_q[VAL_W-1]) begin
						den_q <= -den_q;
						nu_q  <= -nu_q;
						nv_q  <= -nv_q;
					end
				end
				OP_NW:  nw_q  <= den_q - nu_q - nv_q;
				OP_LDS: acc_q <= a_ext <<< FRAC_BITS;
				OP_DIVI: begin
					neg_q  <= acc_q[ACC_W-1];
					numq_q <= (mag << 1) + ACC_W'(den_q);
					rem_q  <= '0;
				end
				OP_DIV: begin
					rem_q  <= ge ? r2 - dvs : r2;
					numq_q <= {numq_q[ACC_W-2:0], ge};
				end
				default: ;
			endcase
		end
	end

	// load is valid and idle, so ready only rises together with valid
	assign cand.ready = cmd.load;
	assign cfg.ready  = 1'b1;
	assign res.valid  = out_valid_q;
	assign res.found  = found_q;
	assign res.height = height_q;

	assign sts.last     = last_q;
	assign sts.hit_ok   = (den_q != '0) && ($unsigned(den_q) >= VAL_W'(lim_q));
	assign sts.acc_neg  = acc_q[ACC_W-1];
	assign sts.out_full = out_valid_q;

endmodule

// ----- rtl/triangle_height_query_max_top.sv -----
// a last item adds an emit state that presents the run result once the output is free
// throughput: one item at a time, set by the shared one-bit-per-cycle multiply-accumulate
// (12 products of 33 steps) and the restoring divider (106 steps)
// reset: async active low, clears control, run state and output valid;
// edge_tolerance returns to 66 and degenerate_limit to 1
module triangle_height_query_max_top
	import thqm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	thqm_cand_if.sink  cand,
	thqm_res_if.source res,
	thqm_cfg_if.sink   cfg
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	thqm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	thqm_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand),
		.res    (res),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ----- bench/tb_triangle_height_query_max_top.sv -----
`timescale 1ns / 1ps
module tb_triangle_height_query_max_top;
	import thqm_pkg::*;

	localparam int ONE = 65536;
	localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(7);
	localparam int SETTLE_CYCLES = 600;

	typedef struct {
		logic signed [31:0] query_x, query_z;
		logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
		logic               last_triangle;
	} tri_item_t;

	typedef struct {
		logic        found;
		logic [31:0] height;
	} height_res_t;

	typedef struct {
		tri_item_t   t;
		bit          typed;
		height_res_t res;
	} query_row_t;

	logic clk;
	logic arst_n;

	thqm_cand_if cand ();
	thqm_res_if  res ();
	thqm_cfg_if  cfg ();

	triangle_height_query_max_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand),
		.res    (res),
		.cfg    (cfg)
	);

	// predictor state
	logic [15:0]        tol_q;
	logic [31:0]        degen_q;
	logic signed [31:0] best_q;
	bit                 have_q;

	height_res_t pending_heights[$];
	int errors;
	int items_sent;
	int results_seen;
	int hits_seen;

	initial begin
		clk = 1'b0;
		forever begin
			#2 clk = 1'b1;
			#2 clk = 1'b0;
		end
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic bit weight_below(logic signed [127:0] n, logic signed [127:0] den);
		logic signed [127:0] tolw;
		tolw = $signed({112'b0, tol_q});
		return ((n <<< 16) + tolw * den) < 0;
	endfunction

	// returns 1 when the item closes a run, with the run result in r
	function automatic bit predict_run_height(tri_item_t t, output height_res_t r);
		logic signed [127:0] qx, qz, ax, ay, az, bx, by, bz, cx, cy, cz;
		logic signed [127:0] den, nu, nv, nw, s, mag, q;
		logic signed [31:0]  h;
		bit hit, neg;
		qx = t.query_x; qz = t.query_z;
		ax = t.a_x; ay = t.a_y; az = t.a_z;
		bx = t.b_x; by = t.b_y; bz = t.b_z;
		cx = t.c_x; cy = t.c_y; cz = t.c_z;
		den = (bz - cz) * (ax - cx) + (cx - bx) * (az - cz);
		nu  = (bz - cz) * (qx - cx) + (cx - bx) * (qz - cz);
		nv  = (cz - az) * (qx - cx) + (ax - cx) * (qz - cz);
		if (den < 0) begin
			den = -den;
			nu = -nu;
			nv = -nv;
		end
		nw = den - nu - nv;
		hit = (den != 0) && (den >= $signed({96'b0, degen_q}));
		if (hit && (weight_below(nu, den) || weight_below(nv, den) || weight_below(nw, den)))
			hit = 0;
		if (hit) begin
			hits_seen++;
			s = nu * ay + nv * by + nw * cy;
			neg = s < 0;
			mag = neg ? -s : s;
			q = (2 * mag + den) / (2 * den);
			if (neg)
				h = (q >= 128'sh8000_0000) ? 32'sh8000_0000 : 32'(-q);
			else
				h = (q > 128'sh7fff_ffff) ? 32'sh7fff_ffff : 32'(q);
			if (!have_q || h > best_q) begin
				best_q = h;
				have_q = 1;
			end
		end
		r.found  = have_q;
		r.height = have_q ? best_q : 32'd0;
		if (!t.last_triangle)
			return 0;
		best_q = 0;
		have_q = 0;
		return 1;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_EDGE_TOL)
			tol_q = data[15:0];
		else if (idx == REG_DEGEN_LIM)
			degen_q = data;
		@(posedge clk);
	endtask

	int gap_left;
	int burst_left;

	task automatic send_tri(query_row_t row);
		height_res_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
		end
		if (gap_left > 0) begin
			cand.valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		burst_left--;
		cand.valid         <= 1'b1;
		cand.query_x       <= row.t.query_x;
		cand.query_z       <= row.t.query_z;
		cand.a_x           <= row.t.a_x;
		cand.a_y           <= row.t.a_y;
		cand.a_z           <= row.t.a_z;
		cand.b_x           <= row.t.b_x;
		cand.b_y           <= row.t.b_y;
		cand.b_z           <= row.t.b_z;
		cand.c_x           <= row.t.c_x;
		cand.c_y           <= row.t.c_y;
		cand.c_z           <= row.t.c_z;
		cand.last_triangle <= row.t.last_triangle;
		do @(posedge clk); while (!cand.ready);
		items_sent++;
		if (predict_run_height(row.t, r))
			pending_heights.insert(pending_heights.size(), row.typed ? row.res : r);
	endtask

	task automatic drain();
		cand.valid <= 1'b0;
		burst_left = 0;
		wait (pending_heights.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic tri_item_t flat_tri(int y, int qx, int qz, bit last);
		tri_item_t t;
		t = '{query_x: qx, query_z: qz, a_x: 0, a_y: y, a_z: 0, b_x: ONE, b_y: y, b_z: 0,
			c_x: 0, c_y: y, c_z: ONE, last_triangle: last};
		return t;
	endfunction

	function automatic tri_item_t fill_tri(logic signed [31:0] v, bit last);
		tri_item_t t;
		t = '{query_x: v, query_z: v, a_x: v, a_y: v, a_z: v, b_x: v, b_y: v, b_z: v,
			c_x: v, c_y: v, c_z: v, last_triangle: last};
		return t;
	endfunction

	function automatic logic signed [31:0] coord(int span);
		return $signed($urandom % (2 * span)) - span;
	endfunction

	function automatic tri_item_t rand_tri(bit last);
		tri_item_t t;
		int span, w1, w2;
		longint q;
		if ($urandom_range(0, 9) < 2) begin
			t = '{query_x: $urandom, query_z: $urandom, a_x: $urandom, a_y: $urandom,
				a_z: $urandom, b_x: $urandom, b_y: $urandom, b_z: $urandom,
				c_x: $urandom, c_y: $urandom, c_z: $urandom, last_triangle: last};
			return t;
		end
		span = 1 << $urandom_range(4, 30);
		t.a_x = coord(span); t.a_z = coord(span);
		t.b_x = coord(span); t.b_z = coord(span);
		t.c_x = coord(span); t.c_z = coord(span);
		t.a_y = $urandom; t.b_y = $urandom; t.c_y = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			t.a_y = coord(span); t.b_y = coord(span); t.c_y = coord(span);
		end
		// query mostly inside, sometimes just past an edge
		w1 = $urandom_range(0, 256);
		w2 = $urandom_range(0, 256 - w1);
		if ($urandom_range(0, 4) == 0)
			w1 = w1 - 1;
		q = longint'(t.c_x) + ((longint'(t.a_x) - t.c_x) * w1 + (longint'(t.b_x) - t.c_x) * w2) / 256;
		t.query_x = 32'(q);
		q = longint'(t.c_z) + ((longint'(t.a_z) - t.c_z) * w1 + (longint'(t.b_z) - t.c_z) * w2) / 256;
		t.query_z = 32'(q);
		t.last_triangle = last;
		return t;
	endfunction

	// result side
	int stall_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_mode = 0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= ($urandom_range(0, 3) != 0);
				default: res.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		height_res_t e;
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (pending_heights.size() == 0) begin
				$error("unexpected result found=%0b height=%0d", res.found, res.height);
				errors++;
			end else begin
				e = pending_heights.pop_front();
				if (res.found !== e.found) begin
					$error("found: expected %0b, got %0b", e.found, res.found);
					errors++;
				end
				if (res.height !== e.height) begin
					$error("height: expected %0d, got %0d", $signed(e.height), res.height);
					errors++;
				end
			end
		end
	end

	query_row_t dir_rows[$];

	function automatic void add_row(query_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	initial begin
		query_row_t row;
		int run_left, phase;
		arst_n = 1'b0;
		cand.valid = 1'b0;
		cand.last_triangle = 1'b0;
		{cand.query_x, cand.query_z, cand.a_x, cand.a_y, cand.a_z} = '0;
		{cand.b_x, cand.b_y, cand.b_z, cand.c_x, cand.c_y, cand.c_z} = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		tol_q = EDGE_TOL_RST;
		degen_q = DEGEN_LIM_RST;
		best_q = 0;
		have_q = 0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		hits_seen = 0;
		burst_left = 0;
		gap_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row('{flat_tri(5 * ONE, 0, 0, 1), 1, '{1'b1, 5 * ONE}});
		add_row('{fill_tri(0, 1), 1, '{1'b0, 32'd0}});
		add_row('{fill_tri(32'sh7fff_ffff, 1), 1, '{1'b0, 32'd0}});
		add_row('{fill_tri(32'sh8000_0000, 1), 1, '{1'b0, 32'd0}});
		add_row('{flat_tri(ONE, 10 * ONE, 10 * ONE, 1), 1, '{1'b0, 32'd0}});
		add_row('{flat_tri(ONE, ONE / 4, ONE / 4, 0), 0, '{1'b0, 32'd0}});
		add_row('{flat_tri(3 * ONE, ONE / 4, ONE / 4, 0), 0, '{1'b0, 32'd0}});
		add_row('{flat_tri(2 * ONE, ONE / 4, ONE / 4, 0), 0, '{1'b0, 32'd0}});
		add_row('{fill_tri(ONE, 1), 1, '{1'b1, 3 * ONE}});
		// extremes of coordinates and heights
		row.t = '{query_x: 0, query_z: 0, a_x: 32'sh8000_0000, a_y: 32'sh7fff_ffff,
			a_z: 32'sh8000_0000, b_x: 32'sh7fff_ffff, b_y: 32'sh8000_0000,
			b_z: 32'sh8000_0000, c_x: 32'sh8000_0000, c_y: 32'sh7fff_ffff,
			c_z: 32'sh7fff_ffff, last_triangle: 1};
		row.typed = 0;
		add_row(row);
		// just past the hypotenuse, both within the default tolerance
		add_row('{flat_tri(ONE, ONE / 2 + 30, ONE / 2, 1), 0, '{1'b0, 32'd0}});
		add_row('{flat_tri(ONE, ONE / 2 + 40, ONE / 2, 1), 0, '{1'b0, 32'd0}});
		// sloped, and saturating with large heights
		row.t = '{query_x: ONE / 3, query_z: ONE / 5, a_x: 0, a_y: -7 * ONE, a_z: 0,
			b_x: ONE, b_y: 9 * ONE, b_z: 0, c_x: 0, c_y: 2 * ONE + 5, c_z: ONE,
			last_triangle: 1};
		add_row(row);
		row.t = '{query_x: ONE / 2 + 60, query_z: ONE / 2, a_x: 0, a_y: 32'sh7fff_ffff,
			a_z: 0, b_x: ONE, b_y: 32'sh7fff_ffff, b_z: 0, c_x: 0, c_y: 32'sh7fff_ffff,
			c_z: ONE, last_triangle: 1};
		add_row(row);
		row.t.a_y = 32'sh8000_0000; row.t.b_y = 32'sh8000_0000; row.t.c_y = 32'sh8000_0000;
		add_row(row);

		foreach (dir_rows[i])
			send_tri(dir_rows[i]);
		drain();
		// the saturation rows hit again under a wide tolerance
		write_reg(REG_EDGE_TOL, 32'd65535);
		write_reg(REG_DEGEN_LIM, 32'd0);
		for (int i = dir_rows.size() - 2; i < dir_rows.size(); i++)
			send_tri(dir_rows[i]);
		send_tri('{fill_tri(0, 1), 1, '{1'b0, 32'd0}});

		row.typed = 0;
		for (phase = 0; phase < 5; phase++) begin
			drain();
			case (phase)
				0: begin
					write_reg(REG_EDGE_TOL, 32'd0);
					write_reg(REG_DEGEN_LIM, 32'd0);
				end
				1: begin
					write_reg(REG_EDGE_TOL, 32'd65535);
					write_reg(REG_DEGEN_LIM, 32'hffff_ffff);
				end
				2: begin
					write_reg(REG_EDGE_TOL, $urandom);
					write_reg(REG_DEGEN_LIM, $urandom >> $urandom_range(0, 31));
					write_reg(REG_UNUSED, $urandom);
				end
				3: begin
					write_reg(REG_EDGE_TOL, 32'(EDGE_TOL_RST));
					write_reg(REG_DEGEN_LIM, DEGEN_LIM_RST);
				end
				default: begin
					write_reg(REG_EDGE_TOL, $urandom_range(0, 2000));
					write_reg(REG_DEGEN_LIM, $urandom_range(0, 1 << 20));
				end
			endcase
			run_left = 0;
			for (int n = 0; n < 165; n++) begin
				if (run_left == 0)
					run_left = $urandom_range(1, 6);
				run_left--;
				row.t = rand_tri(run_left == 0 || n == 164);
				if (row.t.last_triangle)
					run_left = 0;
				send_tri(row);
			end
		end
		drain();

		$display("%0d triangles over several tolerance and limit settings, %0d accepted,",
			items_sent, hits_seen);
		$display("%0d query results checked", results_seen);
		if (errors == 0 && pending_heights.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/thqm_pkg.sv
rtl/thqm_if.sv
rtl/thqm_ctrl.sv
rtl/thqm_dp.sv
rtl/triangle_height_query_max_top.sv
bench/tb_triangle_height_query_max_top.sv
